// ----- hw/rtl/gsms_pkg.sv -----
// Shared types, codes and reset values for the gas sensor measurement sequencer.
`timescale 1ns / 1ps

package gsms_pkg;

    localparam int unsigned IN_DATA_W  = 96;
    localparam int unsigned OUT_DATA_W = 168;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_POLL    = 2'd1,
        FUNC_RECOVER = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_NOT_FOUND  = 3'd0,
        ST_STARTING   = 3'd1,
        ST_WAITING    = 3'd2,
        ST_READY      = 3'd3,
        ST_ERROR      = 3'd4,
        ST_RECOVERING = 3'd5
    } dev_state_t;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_SETTLE     = 2'd1,
        PH_WAIT_READY = 2'd2,
        PH_WAIT_MEAS  = 2'd3
    } phase_t;

    localparam logic [CFG_ADDR_W-1:0] CFG_FAIL_LIMIT        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STALE_TIMEOUT_MS  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_INTERVAL_MS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESPONSE_DELAY_MS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETTLE_DELAY_MS   = 3'd4;

    localparam logic [7:0]  RST_FAIL_LIMIT        = 8'd3;
    localparam logic [30:0] RST_STALE_TIMEOUT_MS  = 31'd60000;
    localparam logic [30:0] RST_START_INTERVAL_MS = 31'd5000;
    localparam logic [15:0] RST_RESPONSE_DELAY_MS = 16'd1;
    localparam logic [15:0] RST_SETTLE_DELAY_MS   = 16'd500;

    typedef struct packed {
        logic [7:0]  fail_limit;
        logic [30:0] stale_timeout_ms;
        logic [30:0] start_interval_ms;
        logic [15:0] response_delay_ms;
        logic [15:0] settle_delay_ms;
    } cfg_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] now_ms;
        logic [3:0]  probe_status;
        logic [3:0]  first_status;
        logic [3:0]  second_status;
        logic        data_ready;
        logic        meas_valid;
        logic [47:0] meas_data;
    } item_t;

    typedef struct packed {
        dev_state_t  dev_state;
        phase_t      phase;
        logic [7:0]  error_run;
        logic [31:0] ok_ops;
        logic [31:0] bad_ops;
        logic [31:0] recoveries;
        logic [3:0]  error_code;
        logic        sample_ok;
        logic [47:0] sample_store;
        logic [31:0] start_time;
        logic [31:0] response_deadline;
        logic [31:0] settle_deadline;
        logic [31:0] sample_time;
    } state_t;

endpackage

// ----- hw/rtl/gsms_step.sv -----
// Next-state and call status logic for one sequencer word.
`timescale 1ns / 1ps

module gsms_step
    import gsms_pkg::*;
(
    input  state_t      cur,
    input  cfg_t        cfg,
    input  item_t       item,
    output state_t      nxt,
    output logic [3:0]  status
);

    logic [31:0] settle_diff;
    logic [31:0] resp_diff;
    logic [31:0] start_age;
    logic [31:0] sample_age;
    logic        settle_reached;
    logic        resp_reached;
    logic        start_due;
    logic        stale;
    state_t      fail_second;
    state_t      pol;

    function automatic state_t note_ok(input state_t s);
        state_t r;
        r = s;
        r.ok_ops = s.ok_ops + 32'd1;
        r.error_run = '0;
        return r;
    endfunction

    function automatic state_t note_fail(input state_t s, input logic [3:0] code);
        state_t r;
        r = s;
        r.error_code = code;
        r.bad_ops = s.bad_ops + 32'd1;
        if (s.error_run != 8'hFF)
        begin
            r.error_run = s.error_run + 8'd1;
        end
        return r;
    endfunction

    function automatic state_t fail_esc(input state_t s, input logic [3:0] code,
                                        input logic [7:0] thr);
        state_t r;
        r = note_fail(s, code);
        if (r.error_run >= thr)
        begin
            r.phase = PH_IDLE;
            r.sample_ok = 1'b0;
            r.dev_state = ST_ERROR;
        end
        return r;
    endfunction

    assign settle_diff    = item.now_ms - cur.settle_deadline;
    assign resp_diff      = item.now_ms - cur.response_deadline;
    assign start_age      = item.now_ms - cur.start_time;
    assign sample_age     = item.now_ms - cur.sample_time;
    assign settle_reached = settle_diff < HALF_RANGE;
    assign resp_reached   = resp_diff < HALF_RANGE;
    assign start_due      = start_age >= {1'b0, cfg.start_interval_ms};
    assign stale          = (cur.dev_state == ST_READY)
                            && (sample_age >= {1'b0, cfg.stale_timeout_ms});

    always_comb
    begin
        fail_second = note_fail(cur, item.second_status);
        fail_second.error_code = item.second_status;
        pol = cur;
        if (stale)
        begin
            pol.sample_ok = 1'b0;
            pol.dev_state = ST_WAITING;
        end
        nxt = cur;
        status = '0;
        case (item.func)
            FUNC_START:
            begin
                if (item.probe_status != 4'd0)
                begin
                    nxt.dev_state = ST_NOT_FOUND;
                    nxt.error_code = item.probe_status;
                    status = item.probe_status;
                end
                else if (item.first_status == 4'd0)
                begin
                    nxt = note_ok(cur);
                    nxt.error_code = '0;
                    nxt.start_time = item.now_ms;
                    nxt.dev_state = ST_STARTING;
                    nxt.phase = PH_IDLE;
                end
                else if (item.second_status != 4'd0)
                begin
                    nxt = fail_second;
                    if (fail_second.error_run >= cfg.fail_limit)
                    begin
                        nxt.dev_state = ST_ERROR;
                    end
                    status = item.second_status;
                end
                else
                begin
                    nxt.error_code = '0;
                    nxt.settle_deadline = item.now_ms + {16'd0, cfg.settle_delay_ms};
                    nxt.dev_state = ST_STARTING;
                    nxt.phase = PH_SETTLE;
                end
            end
            FUNC_POLL:
            begin
                if (cur.dev_state == ST_STARTING)
                begin
                    if (cur.phase == PH_SETTLE)
                    begin
                        if (settle_reached)
                        begin
                            nxt.phase = PH_IDLE;
                            if (item.first_status != 4'd0)
                            begin
                                nxt = fail_esc(nxt, item.first_status, cfg.fail_limit);
                            end
                            else
                            begin
                                nxt = note_ok(nxt);
                                nxt.start_time = item.now_ms;
                                nxt.error_code = '0;
                            end
                        end
                    end
                    else if (start_due)
                    begin
                        nxt.dev_state = ST_WAITING;
                        nxt.phase = PH_IDLE;
                    end
                end
                else if (cur.dev_state == ST_WAITING || cur.dev_state == ST_READY)
                begin
                    nxt = pol;
                    if (cur.error_run >= cfg.fail_limit)
                    begin
                        nxt.phase = PH_IDLE;
                        nxt.sample_ok = 1'b0;
                        nxt.dev_state = ST_ERROR;
                    end
                    else
                    begin
                        case (cur.phase)
                            PH_IDLE:
                            begin
                                if (item.first_status != 4'd0)
                                begin
                                    nxt = fail_esc(pol, item.first_status,
                                                   cfg.fail_limit);
                                end
                                else
                                begin
                                    nxt.response_deadline =
                                        item.now_ms + {16'd0, cfg.response_delay_ms};
                                    nxt.phase = PH_WAIT_READY;
                                end
                            end
                            PH_WAIT_READY:
                            begin
                                if (resp_reached)
                                begin
                                    nxt.phase = PH_IDLE;
                                    if (item.first_status != 4'd0)
                                    begin
                                        nxt = fail_esc(nxt, item.first_status,
                                                       cfg.fail_limit);
                                    end
                                    else if (item.data_ready)
                                    begin
                                        if (item.second_status != 4'd0)
                                        begin
                                            nxt = fail_esc(nxt, item.second_status,
                                                           cfg.fail_limit);
                                        end
                                        else
                                        begin
                                            nxt.response_deadline =
                                                item.now_ms + {16'd0, cfg.response_delay_ms};
                                            nxt.phase = PH_WAIT_MEAS;
                                        end
                                    end
                                end
                            end
                            PH_WAIT_MEAS:
                            begin
                                if (resp_reached)
                                begin
                                    nxt.phase = PH_IDLE;
                                    if (item.first_status != 4'd0)
                                    begin
                                        nxt = fail_esc(nxt, item.first_status,
                                                       cfg.fail_limit);
                                    end
                                    else if (item.meas_valid)
                                    begin
                                        nxt = note_ok(nxt);
                                        nxt.sample_store = item.meas_data;
                                        nxt.sample_ok = 1'b1;
                                        nxt.sample_time = item.now_ms;
                                        nxt.dev_state = ST_READY;
                                        nxt.error_code = '0;
                                    end
                                end
                            end
                            default:
                            begin
                                nxt = pol;
                            end
                        endcase
                    end
                end
            end
            FUNC_RECOVER:
            begin
                nxt.recoveries = cur.recoveries + 32'd1;
                nxt.error_run = '0;
                nxt.sample_ok = 1'b0;
                nxt.dev_state = ST_RECOVERING;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ----- hw/rtl/gas_sensor_measurement_sequencer.sv -----
// Top level of the gas sensor measurement sequencer: config, state and result registers.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser func, s_tdata sensor timestamp and outcomes
//  m_*       out  m_tvalid/m_tready  m_tdata state, counters and sample
//  cfg_*     in   cfg_we             cfg_addr register index, cfg_wdata value
//
// One word is accepted per cycle; its result appears in the output register on the
// next cycle. The whole step is one pass of compare and add logic before the state
// and result registers. s_tready is high while the result register is empty or
// being drained, so a stalled output holds one result and stops the input.
// Reset clears the state register and the output valid flag and loads the register defaults.
`timescale 1ns / 1ps

module gas_sensor_measurement_sequencer
    import gsms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms, probe_status, first_status, second_status, data_ready, meas_valid,
    // meas_data, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // device_state, phase, has_valid_sample, last_error, call_status,
    // fail_run, success_count, failure_count, recover_total,
    // sample_data, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t                  cfg_reg;
    state_t                state_reg;
    state_t                state_next;
    item_t                 item;
    logic [3:0]            status;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;
    logic                  accept;
    logic                  has_sample;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign item.func          = func_t'(s_tuser);
    assign item.now_ms        = s_tdata[31:0];
    assign item.probe_status  = s_tdata[35:32];
    assign item.first_status  = s_tdata[39:36];
    assign item.second_status = s_tdata[43:40];
    assign item.data_ready    = s_tdata[44];
    assign item.meas_valid    = s_tdata[45];
    assign item.meas_data     = s_tdata[93:46];

    gsms_step u_step (
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .item   (item),
        .nxt    (state_next),
        .status (status)
    );

    assign has_sample = (state_next.dev_state == ST_READY) && state_next.sample_ok;

    assign m_tdata_next = {
        2'b00,
        state_next.sample_store,
        state_next.recoveries,
        state_next.bad_ops,
        state_next.ok_ops,
        state_next.error_run,
        status,
        state_next.error_code,
        has_sample,
        state_next.phase,
        state_next.dev_state
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fail_limit        <= RST_FAIL_LIMIT;
            cfg_reg.stale_timeout_ms  <= RST_STALE_TIMEOUT_MS;
            cfg_reg.start_interval_ms <= RST_START_INTERVAL_MS;
            cfg_reg.response_delay_ms <= RST_RESPONSE_DELAY_MS;
            cfg_reg.settle_delay_ms   <= RST_SETTLE_DELAY_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_FAIL_LIMIT:        cfg_reg.fail_limit        <= cfg_wdata[7:0];
                CFG_STALE_TIMEOUT_MS:  cfg_reg.stale_timeout_ms  <= cfg_wdata;
                CFG_START_INTERVAL_MS: cfg_reg.start_interval_ms <= cfg_wdata;
                CFG_RESPONSE_DELAY_MS: cfg_reg.response_delay_ms <= cfg_wdata[15:0];
                CFG_SETTLE_DELAY_MS:   cfg_reg.settle_delay_ms   <= cfg_wdata[15:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

// ----- hw/rtl/gsms_check.sv -----
// Port-level checker for the gas sensor measurement sequencer, bound to the top level.
`timescale 1ns / 1ps

module gsms_check
    import gsms_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [1:0]            s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    a_sample_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> m_tdata[2:0] == ST_READY)
        else $error("valid sample flagged outside ready state");

    a_status_only_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != FUNC_START |=> m_tdata[13:10] == 4'd0)
        else $error("call status set for a non-start word");

endmodule

bind gas_sensor_measurement_sequencer gsms_check u_gsms_check (.*);
